// ===== src/rau_pkg.sv =====
// Package with shared types, constants and command structs of the rational arithmetic unit.
`default_nettype none
package rau_pkg;
  localparam int unsigned Width = 32;
  localparam int unsigned MagW = 65;

  localparam logic [2:0] KindAdd = 3'd0;
  localparam logic [2:0] KindSub = 3'd1;
  localparam logic [2:0] KindMul = 3'd2;
  localparam logic [2:0] KindDiv = 3'd3;
  localparam logic [2:0] KindNeg = 3'd4;
  localparam logic [2:0] KindNorm = 3'd5;
  localparam logic [2:0] KindCmp = 3'd6;
  localparam logic [2:0] KindRsvd = 3'd7;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatZero = 2'd1;
  localparam logic [1:0] StatOvf = 2'd2;

  localparam logic [1:0] OrdLess = 2'd0;
  localparam logic [1:0] OrdEqual = 2'd1;
  localparam logic [1:0] OrdGreater = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0] res_den;
    logic [1:0] order;
    logic [1:0] status;
  } res_t;

  typedef enum logic [2:0] {
    CmdNone, CmdLoad, CmdMul1, CmdMul2, CmdCombine, CmdGcdStep, CmdDivStep, CmdFinish
  } cmd_e;

  typedef struct packed {
    logic early;
    logic gcd_done;
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

// ===== src/rational_arithmetic_unit_core.sv =====
// Top level of the rational arithmetic unit.
// One request at a time: raise start_i while busy_o is low. The result appears on
// res_o with done_o high for one cycle and cannot be stalled. An error or a compare
// ends early; every other operation first runs the bit-serial binary GCD and two
// 65-step restoring divisions before the result is taken.
`default_nettype none
module rational_arithmetic_unit_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  rau_pkg::req_t    req_i,
  output logic             busy_o,
  output logic             done_o,
  output rau_pkg::res_t    res_o
);
  rau_pkg::cmd_e cmd;
  rau_pkg::stat_t stat;
  logic fin;

  rau_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .stat_i(stat),
    .cmd_o(cmd), .busy_o(busy_o), .done_o(fin)
  );

  rau_dp u_dp (
    .clk_i(clk_i), .cmd_i(cmd), .req_i(req_i), .stat_o(stat), .res_o(res_o)
  );

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin;
    end
  end
  assign done_o = done_q;
endmodule
`default_nettype wire

// ===== src/rau_ctrl.sv =====
// Controller state machine that sequences the rational arithmetic unit datapath.
`default_nettype none
module rau_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  rau_pkg::stat_t      stat_i,
  output rau_pkg::cmd_e       cmd_o,
  output logic                busy_o,
  output logic                done_o
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SMul1 = 3'd1;
  localparam logic [2:0] SMul2 = 3'd2;
  localparam logic [2:0] SComb = 3'd3;
  localparam logic [2:0] SGcd = 3'd4;
  localparam logic [2:0] SDiv = 3'd5;
  localparam logic [2:0] SFin = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = rau_pkg::CmdNone;
    done_o = 1'b0;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          cmd_o = rau_pkg::CmdLoad;
          state_d = SMul1;
        end
      end
      SMul1: begin
        if (stat_i.early) begin
          state_d = SFin;
        end else begin
          cmd_o = rau_pkg::CmdMul1;
          state_d = SMul2;
        end
      end
      SMul2: begin
        cmd_o = rau_pkg::CmdMul2;
        state_d = SComb;
      end
      SComb: begin
        cmd_o = rau_pkg::CmdCombine;
        state_d = SGcd;
      end
      SGcd: begin
        if (stat_i.gcd_done) begin
          state_d = SDiv;
        end else begin
          cmd_o = rau_pkg::CmdGcdStep;
        end
      end
      SDiv: begin
        if (stat_i.div_done) begin
          state_d = SFin;
        end else begin
          cmd_o = rau_pkg::CmdDivStep;
        end
      end
      SFin: begin
        cmd_o = rau_pkg::CmdFinish;
        done_o = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != SIdle);
endmodule
`default_nettype wire

// ===== src/rau_dp.sv =====
// Datapath with operand registers, cross products, binary GCD and restoring divider.
`default_nettype none
module rau_dp (
  input  wire logic        clk_i,
  input  rau_pkg::cmd_e    cmd_i,
  input  rau_pkg::req_t    req_i,
  output rau_pkg::stat_t   stat_o,
  output rau_pkg::res_t    res_o
);
  localparam int unsigned MW = rau_pkg::MagW;
  localparam logic [MW-1:0] Lim = MW'(1) << (rau_pkg::Width - 1);

  logic [2:0] kind_q;
  logic [31:0] an_q, ad_q, bn_q, bd_q;
  logic ann_q, adn_q, bnn_q, bdn_q;
  logic [63:0] p1_q, p2_q;
  logic [MW-1:0] num_q, den_q, gx_q, gy_q, g_q, rem_q, quo_q, dvd_q;
  logic [7:0] sh_q, cnt_q;
  logic nneg_q, dneg_q, early_q, gdone_q, div_phase_q;
  logic [1:0] estat_q, order_q;
  rau_pkg::res_t res_q;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  logic [31:0] lan, lad, lbn, lbd;
  logic lbad;
  assign lan = mag32(req_i.a_num);
  assign lad = mag32(req_i.a_den);
  assign lbn = mag32(req_i.b_num);
  assign lbd = mag32(req_i.b_den);
  always_comb begin
    lbad = 1'b0;
    if (req_i.kind == rau_pkg::KindRsvd || lad == 32'd0) lbad = 1'b1;
    if (req_i.kind != rau_pkg::KindNeg && req_i.kind != rau_pkg::KindNorm && lbd == 32'd0)
      lbad = 1'b1;
    if (req_i.kind == rau_pkg::KindDiv && lbn == 32'd0) lbad = 1'b1;
  end

  logic s1, s2;
  logic [MW-1:0] cn, cd, m1, m2;
  logic cnn, cdn;
  always_comb begin
    s1 = (p1_q != 64'd0) && (ann_q != bdn_q);
    s2 = (p2_q != 64'd0) && (bnn_q != adn_q);
    if (kind_q == rau_pkg::KindSub) s2 = (p2_q != 64'd0) && !s2;
    m1 = {1'b0, p1_q};
    m2 = {1'b0, p2_q};
    if (s1 == s2) begin
      cn = m1 + m2; cnn = s1;
    end else if (m1 >= m2) begin
      cn = m1 - m2; cnn = s1;
    end else begin
      cn = m2 - m1; cnn = s2;
    end
    cd = {33'd0, ad_q} * {33'd0, bd_q};
    cdn = adn_q != bdn_q;
    case (kind_q)
      rau_pkg::KindMul: begin
        cn = m1; cnn = ann_q != bnn_q; cd = m2; cdn = adn_q != bdn_q;
      end
      rau_pkg::KindDiv: begin
        cn = m1; cnn = ann_q != bdn_q; cd = m2; cdn = adn_q != bnn_q;
      end
      rau_pkg::KindNeg: begin
        cn = {33'd0, an_q}; cnn = !ann_q; cd = {33'd0, ad_q}; cdn = adn_q;
      end
      rau_pkg::KindNorm: begin
        cn = {33'd0, an_q}; cnn = ann_q; cd = {33'd0, ad_q}; cdn = adn_q;
      end
      default: ;
    endcase
  end

  logic [1:0] ord;
  always_comb begin
    if (s1 != s2) ord = s1 ? rau_pkg::OrdLess : rau_pkg::OrdGreater;
    else if (p1_q == p2_q) ord = rau_pkg::OrdEqual;
    else if (s1 == (p1_q > p2_q)) ord = rau_pkg::OrdLess;
    else ord = rau_pkg::OrdGreater;
    if (adn_q != bdn_q && ord != rau_pkg::OrdEqual)
      ord = (ord == rau_pkg::OrdLess) ? rau_pkg::OrdGreater : rau_pkg::OrdLess;
  end

  logic [MW-1:0] trial, rd;
  logic rnn;
  assign trial = {rem_q[MW-2:0], dvd_q[MW-1]};
  assign rd = quo_q;
  assign rnn = (num_q != 0) && (nneg_q != dneg_q);

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      rau_pkg::CmdLoad: begin
        kind_q <= req_i.kind;
        an_q <= lan; ad_q <= lad; bn_q <= lbn; bd_q <= lbd;
        ann_q <= req_i.a_num[31] && lan != 0; adn_q <= req_i.a_den[31];
        bnn_q <= req_i.b_num[31] && lbn != 0; bdn_q <= req_i.b_den[31];
        early_q <= lbad;
        estat_q <= rau_pkg::StatZero;
        order_q <= rau_pkg::OrdLess;
      end
      rau_pkg::CmdMul1: p1_q <= an_q * ((kind_q == rau_pkg::KindMul) ? bn_q : bd_q);
      rau_pkg::CmdMul2: p2_q <=
          ((kind_q == rau_pkg::KindMul || kind_q == rau_pkg::KindDiv) ? ad_q : bn_q) *
          ((kind_q == rau_pkg::KindMul) ? bd_q :
           ((kind_q == rau_pkg::KindDiv) ? bn_q : ad_q));
      rau_pkg::CmdCombine: begin
        num_q <= cn; den_q <= cd; nneg_q <= cn != 0 && cnn; dneg_q <= cdn;
        gx_q <= cn; gy_q <= cd; sh_q <= '0; gdone_q <= 1'b0;
        div_phase_q <= 1'b0;
        if (kind_q == rau_pkg::KindCmp) begin
          early_q <= 1'b1; estat_q <= rau_pkg::StatOk; order_q <= ord;
          gdone_q <= 1'b1;
        end
      end
      rau_pkg::CmdGcdStep: begin
        if (gx_q == 0) begin
          g_q <= gy_q << sh_q; gdone_q <= 1'b1;
        end else if (!gx_q[0] && !gy_q[0]) begin
          gx_q <= gx_q >> 1; gy_q <= gy_q >> 1; sh_q <= sh_q + 8'd1;
        end else if (!gx_q[0]) begin
          gx_q <= gx_q >> 1;
        end else if (!gy_q[0]) begin
          gy_q <= gy_q >> 1;
        end else if (gx_q >= gy_q) begin
          gx_q <= (gx_q - gy_q) >> 1;
        end else begin
          gy_q <= (gy_q - gx_q) >> 1;
        end
        cnt_q <= 8'd0; rem_q <= '0; quo_q <= '0; dvd_q <= num_q;
      end
      rau_pkg::CmdDivStep: begin
        if (trial >= g_q) begin
          rem_q <= trial - g_q; quo_q <= {quo_q[MW-2:0], 1'b1};
        end else begin
          rem_q <= trial; quo_q <= {quo_q[MW-2:0], 1'b0};
        end
        dvd_q <= dvd_q << 1;
        if (cnt_q == 8'(MW - 1)) begin
          cnt_q <= 8'd0;
          if (div_phase_q) begin
            div_phase_q <= 1'b0;
            cnt_q <= 8'd255;
          end else begin
            div_phase_q <= 1'b1;
            num_q <= {quo_q[MW-2:0], trial >= g_q};
            dvd_q <= den_q; rem_q <= '0;
          end
        end else begin
          cnt_q <= cnt_q + 8'd1;
        end
      end
      rau_pkg::CmdFinish: begin
        res_q.res_num <= '0; res_q.res_den <= 31'd1;
        res_q.order <= order_q; res_q.status <= estat_q;
        if (!early_q) begin
          res_q.order <= rau_pkg::OrdLess;
          if (rd > Lim - 1 || num_q > (rnn ? Lim : Lim - 1)) begin
            res_q.status <= rau_pkg::StatOvf;
          end else begin
            res_q.status <= rau_pkg::StatOk;
            res_q.res_num <= rnn ? (~num_q[31:0] + 32'd1) : num_q[31:0];
            res_q.res_den <= rd[30:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign stat_o.early = early_q;
  assign stat_o.gcd_done = gdone_q;
  assign stat_o.div_done = (cnt_q == 8'd255) || early_q;
  assign res_o = res_q;
endmodule
`default_nettype wire
